/* rtl/oaid_pkg.sv */
package oaid_pkg;

  // fixed field widths of the item formats
  localparam int WORD_W   = 32;
  localparam int LOC_W    = 7;
  localparam int COUNT_W  = 8;
  localparam int DEPTH_DEF = 128;

  typedef enum logic [1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_END   = 2'd1,
    OP_INS_AT    = 2'd2,
    OP_DEL_FRONT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADLOC = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SG_POS,
    SG_NEG,
    SG_ZERO
  } sign_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_HEADW,
    S_RD,
    S_WR,
    S_PUT,
    S_DROP,
    S_DONE
  } state_t;

  // sign class of a stored word
  function automatic sign_t sign_of(input logic [WORD_W-1:0] w);
    sign_t s;
    if (w == '0) begin
      s = SG_ZERO;
    end else if (w[WORD_W-1]) begin
      s = SG_NEG;
    end else begin
      s = SG_POS;
    end
    return s;
  endfunction

endpackage

/* rtl/ordered_array_insert_delete.sv */
// Ordered array of signed 32-bit words with insert front, insert end, insert at a
// location and delete front; each item returns one result with status, the removed
// word and the size and sign counts after the operation. The words live in a single
// memory with one write port and one registered read port, and elements are moved
// one at a time by a small sequencer: each moved element is first read, then written.
// The block accepts one item at a time and takes the next one while the previous
// result still waits in the output register.
module ordered_array_insert_delete
  import oaid_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value[31:0], location[38:32], zero pad
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // removed_value[31:0], fill_size[39:32],
                                      // positive_count[47:40], negative_count[55:48],
                                      // zero_count[63:56]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > LOC_W) ? CW : LOC_W;

  state_t state, state_next;

  logic [CW-1:0]     size, pos_total, neg_total, zero_total;
  logic [AW-1:0]     ptr, at;
  logic              is_del;
  logic [WORD_W-1:0] value, removed;
  status_t           stat;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic              in_acc, out_free;
  op_t               op_in;
  logic [WORD_W-1:0] value_in;
  logic [LOC_W-1:0]  loc_in;
  logic [AW-1:0]     at_in;
  status_t           stat_in;
  logic [AW-1:0]     nb;
  logic              more;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign op_in    = op_t'(s_axis_tuser);
  assign value_in = s_axis_tdata[WORD_W-1:0];
  assign loc_in   = s_axis_tdata[WORD_W +: LOC_W];

  // request check and target position
  always_comb begin
    stat_in = STAT_OK;
    at_in   = '0;
    unique case (op_in)
      OP_DEL_FRONT: begin
        if (size == '0) stat_in = STAT_EMPTY;
      end
      OP_INS_FRONT: begin
        if (size == CW'(DEPTH)) stat_in = STAT_FULL;
      end
      OP_INS_END: begin
        at_in = AW'(size);
        if (size == CW'(DEPTH)) stat_in = STAT_FULL;
      end
      OP_INS_AT: begin
        at_in = AW'(loc_in);
        if (size == CW'(DEPTH)) begin
          stat_in = STAT_FULL;
        end else if (XW'(loc_in) > XW'(size)) begin
          stat_in = STAT_BADLOC;
        end
      end
      default: stat_in = STAT_OK;
    endcase
  end

  // shared step unit: neighbor index and loop test
  assign nb   = is_del ? ptr + AW'(1) : ptr - AW'(1);
  assign more = is_del ? (CW'(nb) + CW'(1) < size) : (nb != at);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (stat_in != STAT_OK) begin
            state_next = S_DONE;
          end else if (op_in == OP_DEL_FRONT) begin
            state_next = S_HEAD;
          end else if (CW'(at_in) < size) begin
            state_next = S_RD;
          end else begin
            state_next = S_PUT;
          end
        end
      end
      S_HEAD:  state_next = S_HEADW;
      S_HEADW: state_next = (size > CW'(1)) ? S_RD : S_DROP;
      S_RD:    state_next = S_WR;
      S_WR: begin
        if (more) begin
          state_next = S_RD;
        end else begin
          state_next = is_del ? S_DROP : S_PUT;
        end
      end
      S_PUT:   state_next = S_DONE;
      S_DROP:  state_next = S_DONE;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls and input ready
  always_comb begin
    s_axis_tready = (state == S_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = ptr;
    ram_wdata     = ram_rdata;
    ram_raddr     = nb;
    unique case (state)
      S_HEAD: ram_raddr = '0;
      S_WR:   ram_we = 1'b1;
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = at;
        ram_wdata = value;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      size          <= '0;
      pos_total     <= '0;
      neg_total     <= '0;
      zero_total    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // result valid: raised when the payload is loaded, dropped when taken
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_PUT: begin
          size <= size + CW'(1);
          unique case (sign_of(value))
            SG_POS:  pos_total  <= pos_total + CW'(1);
            SG_NEG:  neg_total  <= neg_total + CW'(1);
            default: zero_total <= zero_total + CW'(1);
          endcase
        end
        S_DROP: begin
          size <= size - CW'(1);
          unique case (sign_of(removed))
            SG_POS:  pos_total  <= pos_total - CW'(1);
            SG_NEG:  neg_total  <= neg_total - CW'(1);
            default: zero_total <= zero_total - CW'(1);
          endcase
        end
        default: ;
      endcase
    end
  end

  // item registers, loop pointer and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          value   <= value_in;
          at      <= at_in;
          is_del  <= (op_in == OP_DEL_FRONT);
          stat    <= stat_in;
          removed <= '0;
          ptr     <= (op_in == OP_DEL_FRONT) ? '0 : AW'(size);
        end
      end
      S_HEADW: removed <= ram_rdata;
      S_WR:    ptr <= nb;
      S_DONE: begin
        if (out_free) begin
          m_axis_tuser <= stat;
          m_axis_tdata <= {COUNT_W'(zero_total), COUNT_W'(neg_total),
                           COUNT_W'(pos_total), COUNT_W'(size), removed};
        end
      end
      default: ;
    endcase
  end

  oaid_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* rtl/oaid_ram.sv */
module oaid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
